### hw/rtl/bsh_pkg.sv
// ----------------------------------------------------------------------------
// bsh_pkg
// Shared types and constants for the bounded sample history block.
// ----------------------------------------------------------------------------
package bsh_pkg;

  localparam int DEPTH        = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int ADDR_WIDTH   = $clog2(DEPTH);
  localparam int COUNT_WIDTH  = $clog2(DEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] DEPTH_COUNT = COUNT_WIDTH'(DEPTH);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [COUNT_WIDTH-1:0]         count_t;
  typedef logic [ADDR_WIDTH-1:0]          addr_t;

  typedef enum logic {
    ACT_ADD      = 1'b0,
    ACT_RETRIEVE = 1'b1
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // an item is taken this cycle
    logic add;     // the item appends a sample
    logic start;   // the item opens a retrieve with at least one result
    logic issue;   // launch one read step
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic advance;    // the read pipeline moves this cycle
    logic get_empty;  // the offered retrieve asks for no results
    logic last_step;  // the current read step is the final one
  } stat_t;

endpackage

### hw/rtl/bsh_in_if.sv
// ----------------------------------------------------------------------------
// bsh_in_if
// Input item channel: add or retrieve request.
// ----------------------------------------------------------------------------
interface bsh_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  bsh_pkg::sample_t         sample_in;
  bsh_pkg::count_t          count_requested;

  modport source (output valid, action, sample_in, count_requested, input ready);
  modport sink   (input valid, action, sample_in, count_requested, output ready);
endinterface

### hw/rtl/bsh_out_if.sv
// ----------------------------------------------------------------------------
// bsh_out_if
// Result channel: one retrieved sample per word.
// ----------------------------------------------------------------------------
interface bsh_out_if;
  logic             valid;
  logic             ready;
  bsh_pkg::sample_t sample_out;
  logic             sample_valid;
  logic             last;

  modport source (output valid, sample_out, sample_valid, last, input ready);
  modport sink   (input valid, sample_out, sample_valid, last, output ready);
endinterface

### hw/rtl/bsh_cfg_if.sv
// ----------------------------------------------------------------------------
// bsh_cfg_if
// Configuration write channel for the max_samples register.
// ----------------------------------------------------------------------------
interface bsh_cfg_if;
  logic            valid;
  logic            ready;
  bsh_pkg::count_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/bounded_sample_history.sv
// ----------------------------------------------------------------------------
// bounded_sample_history
// Ring history of the newest samples under a configurable limit.
// ----------------------------------------------------------------------------
// Add: no result word.
// Retrieve of N words: each read passes a read stage and a result register;
// one word per cycle unless the receiver stalls; the next item is taken once
// all N reads have issued. One read port on the sample store sets that pace.
// Synchronous reset clears counters and pipeline, sets max_samples to 64;
// sample store contents are not cleared.
module bounded_sample_history (
  input  logic      clk,
  input  logic      rst,
  bsh_in_if.sink    item,
  bsh_cfg_if.sink   cfg,
  bsh_out_if.source result
);
  import bsh_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bsh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_action (item.action),
    .in_ready  (item.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bsh_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .sample_in       (item.sample_in),
    .count_requested (item.count_requested),
    .cmd             (cmd),
    .stat            (stat),
    .cfg             (cfg),
    .result          (result)
  );

endmodule

### hw/rtl/bsh_ctrl.sv
// ----------------------------------------------------------------------------
// bsh_ctrl
// Controller: takes items while idle and steps through retrieve reads.
// ----------------------------------------------------------------------------
module bsh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  input  bsh_pkg::stat_t stat,
  output bsh_pkg::cmd_t  cmd
);
  import bsh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_RETRIEVE && !stat.get_empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (stat.advance && stat.last_step) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.add    = in_valid && in_action == ACT_ADD;
        cmd.start  = in_valid && in_action == ACT_RETRIEVE && !stat.get_empty;
      end
      ST_READ: begin
        cmd.issue = stat.advance;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/bsh_datapath.sv
// ----------------------------------------------------------------------------
// bsh_datapath
// Ring store, counters, limit register and the two-stage read pipeline.
// ----------------------------------------------------------------------------
module bsh_datapath (
  input  logic             clk,
  input  logic             rst,
  input  bsh_pkg::sample_t sample_in,
  input  bsh_pkg::count_t  count_requested,
  input  bsh_pkg::cmd_t    cmd,
  output bsh_pkg::stat_t   stat,
  bsh_cfg_if.sink          cfg,
  bsh_out_if.source        result
);
  import bsh_pkg::*;

  sample_t mem [DEPTH];

  count_t  max_samples;
  addr_t   write_position;
  count_t  stored_count;
  logic [31:0] total_added;

  count_t  limit;
  count_t  trimmed;
  count_t  req_len;
  count_t  req_n;
  count_t  step;
  count_t  step_inc;
  addr_t   read_addr;

  sample_t read_data;
  logic    s1_valid;
  logic    s1_sample_valid;
  logic    s1_last;
  logic    s2_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= DEPTH_COUNT;
    end else if (cfg.valid) begin
      max_samples <= cfg.data;
    end
  end

  assign limit    = (max_samples > DEPTH_COUNT) ? DEPTH_COUNT : max_samples;
  // apply any pending trim from a lowered limit
  assign trimmed  = (stored_count > limit) ? limit : stored_count;
  assign req_len  = (count_requested == '0) ? limit :
                    ((count_requested > DEPTH_COUNT) ? DEPTH_COUNT : count_requested);
  assign step_inc = step + count_t'(1);

  assign stat.get_empty = (req_len == '0);
  assign stat.last_step = (step_inc == req_n);
  assign stat.advance   = !s2_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      stored_count   <= '0;
      total_added    <= '0;
    end else if (cmd.accept) begin
      stored_count <= trimmed;
      if (cmd.add) begin
        total_added <= total_added + 32'd1;
        if (limit != '0) begin
          write_position <= write_position + addr_t'(1);
          if (trimmed < limit) begin
            stored_count <= trimmed + count_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && limit != '0) begin
      mem[write_position] <= sample_in;
    end
  end

  // newest first: walk back from the slot before the write position
  assign read_addr = write_position - addr_t'(1) - step[ADDR_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_n <= req_len;
      step  <= '0;
    end else if (cmd.issue) begin
      step  <= step_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      read_data       <= mem[read_addr];
      s1_sample_valid <= (step < stored_count);
      s1_last         <= stat.last_step;
    end
  end

  // hold both stages while the result word is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (stat.advance) begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.advance && s1_valid) begin
      result.sample_out   <= s1_sample_valid ? read_data : '0;
      result.sample_valid <= s1_sample_valid;
      result.last         <= s1_last;
    end
  end

  assign result.valid = s2_valid;

endmodule

### dv/bsh_history_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsh_history_checker
// Watches the item, configuration and result channels, keeps its own copy
// of the sample ring and limit, predicts the retrieved words and compares
// every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module bsh_history_checker (
  input  logic clk,
  input  logic rst,
  bsh_in_if    item,
  bsh_cfg_if   cfg,
  bsh_out_if   result,
  output int   failures,
  output int   pending
);
  import bsh_pkg::*;

  localparam int DUE_SLOTS = 256;

  typedef struct packed {
    sample_t value;
    logic    stored;
    logic    tail;
  } history_word_t;

  sample_t       ring [DEPTH];
  addr_t         next_slot;
  count_t        held;
  count_t        limit_reg;
  // predicted words waiting for the result channel, oldest at due_head
  history_word_t due_words [DUE_SLOTS];
  logic [7:0]    due_head;
  logic [7:0]    due_tail;
  int            fail_count = 0;

  assign failures = fail_count;

  task automatic log_failure(input string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Apply one accepted item to the ring copy and queue the words it yields.
  task automatic replay_history_item(input action_t act, input sample_t value,
                                     input count_t requested);
    count_t        lim;
    count_t        n;
    history_word_t w;
    lim = (limit_reg > DEPTH_COUNT) ? DEPTH_COUNT : limit_reg;
    // drop the oldest entries left over from a lowered limit
    if (held > lim) held = lim;
    if (act == ACT_ADD) begin
      if (lim != 0) begin
        ring[next_slot] = value;
        next_slot = next_slot + addr_t'(1);
        if (held < lim) held = held + count_t'(1);
      end
    end else begin
      n = (requested == 0) ? lim : requested;
      if (n > DEPTH_COUNT) n = DEPTH_COUNT;
      for (int k = 0; k < n; k++) begin
        if (k < held) begin
          w.value  = ring[addr_t'(next_slot - 1 - k)];
          w.stored = 1'b1;
        end else begin
          w.value  = '0;
          w.stored = 1'b0;
        end
        w.tail = (k + 1 == n);
        due_words[due_tail] = w;
        due_tail = due_tail + 8'd1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    history_word_t want;
    logic [7:0]    due_fill;
    if (rst) begin
      next_slot = '0;
      held      = '0;
      limit_reg = DEPTH_COUNT;
      due_head  = '0;
      due_tail  = '0;
    end else begin
      if (cfg.valid && cfg.ready) limit_reg = cfg.data;
      if (item.valid && item.ready) begin
        replay_history_item(action_t'(item.action), item.sample_in, item.count_requested);
      end
      if (result.valid && result.ready) begin
        if (due_head == due_tail) begin
          log_failure($sformatf("unexpected word: got value %h valid %b last %b",
                                result.sample_out, result.sample_valid, result.last));
        end else begin
          want = due_words[due_head];
          due_head = due_head + 8'd1;
          if (result.sample_out !== want.value || result.sample_valid !== want.stored ||
              result.last !== want.tail) begin
            log_failure($sformatf(
              "word mismatch: expected value %h valid %b last %b, got %h %b %b",
              want.value, want.stored, want.tail,
              result.sample_out, result.sample_valid, result.last));
          end
        end
      end
    end
    due_fill = due_tail - due_head;
    pending <= int'(due_fill);
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add and retrieve items and limit writes into the sample history,
// with random idle cycles on both sides, and reports the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import bsh_pkg::*;

  logic clk;
  logic rst;
  logic steady;
  int   failures;
  int   pending;

  bsh_in_if  item_if ();
  bsh_cfg_if cfg_if ();
  bsh_out_if result_if ();

  bounded_sample_history DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .cfg    (cfg_if),
    .result (result_if)
  );

  bsh_history_checker watcher (
    .clk      (clk),
    .rst      (rst),
    .item     (item_if),
    .cfg      (cfg_if),
    .result   (result_if),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver stalls about one cycle in ten unless in a steady stretch.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_if.ready <= !rst && (steady || $urandom_range(0, 99) >= 10);
    end
  end

  task automatic send_item(input action_t act, input sample_t value, input count_t requested);
    bit lowered;
    lowered = 1'b0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 10) begin
        if (!lowered) item_if.valid <= 1'b0;
        lowered = 1'b1;
        @(posedge clk);
      end
    end
    item_if.valid           <= 1'b1;
    item_if.action          <= act;
    item_if.sample_in       <= value;
    item_if.count_requested <= requested;
    do @(posedge clk); while (item_if.ready !== 1'b1);
  endtask

  // Hold off the sender until every predicted word has been taken.
  task automatic drain_history();
    item_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input count_t value);
    drain_history();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly short retrieves, a few default-length and oversized ones.
  function automatic count_t pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return count_t'($urandom_range(64, 127));
    if (r < 25) return count_t'($urandom_range(13, 63));
    return count_t'($urandom_range(1, 12));
  endfunction

  initial begin
    count_t phase_limit [8];
    int     phase_items [8];
    int     phase_adds  [8];
    count_t lim;

    phase_limit             = '{7'd64, 7'd1, 7'd127, 7'd7, 7'd0, 7'd33, 7'd64, 7'd0};
    phase_items             = '{60, 30, 80, 40, 25, 50, 40, 35};
    phase_adds              = '{75, 50, 80, 60, 50, 65, 50, 60};
    steady                  = 1'b0;
    rst                    <= 1'b1;
    item_if.valid          <= 1'b0;
    item_if.action         <= ACT_ADD;
    item_if.sample_in      <= '0;
    item_if.count_requested <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.data            <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty history gives padding only
    send_item(ACT_RETRIEVE, '0, 7'd1);
    send_item(ACT_ADD, sample_t'(32'h8000_0000), 7'd127);
    send_item(ACT_ADD, sample_t'(32'h7FFF_FFFF), 7'd0);
    send_item(ACT_ADD, sample_t'(32'h0000_0000), 7'd64);
    send_item(ACT_ADD, sample_t'(32'hFFFF_FFFF), 7'd3);
    send_item(ACT_ADD, sample_t'(32'h0001_0000), 7'd1);
    send_item(ACT_ADD, sample_t'(32'h5555_5555), 7'd42);
    send_item(ACT_RETRIEVE, '0, 7'd0);
    send_item(ACT_RETRIEVE, '0, 7'd3);
    send_item(ACT_RETRIEVE, sample_t'(32'hAAAA_AAAA), 7'd127);
    send_item(ACT_RETRIEVE, '0, 7'd64);
    // lowered limit trims at the next item
    write_limit(7'd2);
    send_item(ACT_RETRIEVE, '0, 7'd4);
    send_item(ACT_ADD, sample_t'(32'h1234_5678), 7'd0);
    send_item(ACT_RETRIEVE, '0, 7'd0);
    // zero limit: adds store nothing, default retrieve yields no word
    write_limit(7'd0);
    send_item(ACT_ADD, sample_t'(32'hFEDC_BA98), 7'd5);
    send_item(ACT_RETRIEVE, '0, 7'd0);
    send_item(ACT_RETRIEVE, '0, 7'd3);
    // limit above depth acts as depth
    write_limit(7'd127);
    send_item(ACT_RETRIEVE, '0, 7'd2);
    send_item(ACT_ADD, sample_t'(32'h0000_0001), 7'd0);
    send_item(ACT_RETRIEVE, '0, 7'd0);

    foreach (phase_limit[p]) begin
      lim = (p == 7) ? count_t'($urandom_range(0, 127)) : phase_limit[p];
      write_limit(lim);
      steady = (p == 2);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 3 && i == phase_items[p] / 2) drain_history();
        if ($urandom_range(0, 99) < phase_adds[p]) begin
          send_item(ACT_ADD, sample_t'($urandom()), count_t'($urandom_range(0, 127)));
        end else begin
          send_item(ACT_RETRIEVE, sample_t'($urandom()), pick_count());
        end
      end
    end
    steady = 1'b0;

    drain_history();
    if (failures == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
